// ----- src/scsaw_pkg.sv -----
`timescale 1ns / 1ps

package scsaw_pkg;

  localparam int unsigned ByteW = 8;

  // serial command codes
  localparam logic [ByteW-1:0] CmdRise  = 8'd1;
  localparam logic [ByteW-1:0] CmdFall  = 8'd2;
  localparam logic [ByteW-1:0] CmdStop  = 8'd4;
  localparam logic [ByteW-1:0] SyncByte = 8'd255;

  // item kinds carried on the input tuser
  localparam logic KindByte = 1'b0;
  localparam logic KindTick = 1'b1;

  localparam logic [ByteW-1:0] FullScaleRst  = 8'd100;
  localparam logic [ByteW-1:0] StepPeriodRst = 8'd10;

endpackage

// ----- src/serial_commanded_sawtooth_pwm_ramp.sv -----
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)   tuser (low bit up)
// s_axis    in   rx_byte[7:0]         command (0 byte, 1 tick)
// m_axis    out  duty[7:0]            duty_written
// cfg       in   full_scale[7:0]      -
//
// Two stages: an input register, then the parser/ramp update feeding the result
// register. One item per cycle sustained while m_axis does not stall.
// The ramp state is updated as an item enters the result register.
// Reset: parser idle, valid and level clear, running, period 10, full_scale 100.
// A stalled m_axis holds the result; the input register still takes one item.

module serial_commanded_sawtooth_pwm_ramp (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // rx_byte[7:0]
  input  logic       s_axis_tuser_i,   // command
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // duty[7:0]
  output logic       m_axis_tuser_o,   // duty_written
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i        // full_scale[7:0]
);

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhCmd  = 2'd1,
    PhData = 2'd2
  } phase_e;

  logic [7:0] full_scale_q;

  logic       in_valid_q;
  logic       in_kind_q;
  logic [7:0] in_byte_q;

  logic       out_valid_q;
  logic [7:0] out_duty_q;
  logic       out_wr_q;

  phase_e     phase_q, phase_d;
  logic [7:0] held_cmd_q, held_cmd_d;
  logic [7:0] period_q, period_d;
  logic [7:0] tick_cnt_q, tick_cnt_d;
  logic       running_q, running_d;
  logic       falling_q, falling_d;
  logic [7:0] level_q, level_d;
  logic       wr_d;

  logic       advance;
  logic [7:0] full_eff;
  logic [8:0] cnt_inc;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_duty_q;
  assign m_axis_tuser_o  = out_wr_q;

  assign full_eff = (full_scale_q == '0) ? 8'd1 : full_scale_q;
  assign cnt_inc  = {1'b0, tick_cnt_q} + 9'd1;

  always_comb begin
    phase_d    = phase_q;
    held_cmd_d = held_cmd_q;
    period_d   = period_q;
    tick_cnt_d = tick_cnt_q;
    running_d  = running_q;
    falling_d  = falling_q;
    level_d    = level_q;
    wr_d       = 1'b0;

    if (in_kind_q == scsaw_pkg::KindTick) begin
      if (running_q) begin
        if (cnt_inc < {1'b0, period_q}) begin
          tick_cnt_d = cnt_inc[7:0];
        end else begin
          tick_cnt_d = '0;
          wr_d       = 1'b1;
          if (!falling_q) begin
            level_d = (level_q >= full_eff) ? 8'd1 : level_q + 8'd1;
          end else begin
            level_d = (level_q == '0) ? full_eff - 8'd1 : level_q - 8'd1;
          end
        end
      end
    end else if (in_byte_q == scsaw_pkg::SyncByte) begin
      phase_d = PhCmd;
    end else begin
      unique case (phase_q)
        PhIdle: phase_d = PhCmd;
        PhCmd: begin
          held_cmd_d = in_byte_q;
          phase_d    = PhData;
        end
        PhData: begin
          phase_d   = PhIdle;
          period_d  = in_byte_q;
          running_d = 1'b1;
          priority if (held_cmd_q == scsaw_pkg::CmdStop) begin
            running_d = 1'b0;
            level_d   = '0;
            wr_d      = 1'b1;
          end else if (held_cmd_q == scsaw_pkg::CmdFall) begin
            falling_d = 1'b1;
            level_d   = full_eff;
            wr_d      = 1'b1;
          end else if (held_cmd_q == scsaw_pkg::CmdRise) begin
            falling_d = 1'b0;
            level_d   = '0;
            wr_d      = 1'b1;
          end else begin
            wr_d = 1'b0;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= scsaw_pkg::FullScaleRst;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PhIdle;
      held_cmd_q   <= '0;
      period_q     <= scsaw_pkg::StepPeriodRst;
      tick_cnt_q   <= '0;
      running_q    <= 1'b1;
      falling_q    <= 1'b0;
      level_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        full_scale_q <= cfg_data_i;
      end
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        held_cmd_q  <= held_cmd_d;
        period_q    <= period_d;
        tick_cnt_q  <= tick_cnt_d;
        running_q   <= running_d;
        falling_q   <= falling_d;
        level_q     <= level_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_kind_q <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_duty_q <= level_d;
      out_wr_q   <= wr_d;
    end
  end

endmodule

// ----- tb/sv/serial_commanded_sawtooth_pwm_ramp_tb.sv -----
`timescale 1ns / 1ps

module serial_commanded_sawtooth_pwm_ramp_tb;

  localparam int unsigned CycleLimit = 400000;

  // parser phases
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhCmd  = 2'd1;
  localparam logic [1:0] PhData = 2'd2;

  typedef struct packed {
    logic [7:0] duty;
    logic       written;
  } duty_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tuser = scsaw_pkg::KindByte;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  serial_commanded_sawtooth_pwm_ramp DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // rx_byte[7:0]
    .s_axis_tuser_i  (s_tuser),   // command
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // duty[7:0]
    .m_axis_tuser_o  (m_tuser),   // duty_written
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)   // full_scale[7:0]
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ramp predictor state
  logic [7:0] ramp_full;
  logic [1:0] ramp_phase;
  logic [7:0] ramp_held;
  logic [7:0] ramp_period;
  logic [7:0] ramp_ticks;
  logic       ramp_running;
  logic       ramp_falling;
  logic [7:0] ramp_level;

  duty_result_t duty_q[$];
  int unsigned  fails = 0;
  int unsigned  cycles = 0;
  int           burst_left = 0;

  task automatic ramp_reset();
    ramp_full    = scsaw_pkg::FullScaleRst;
    ramp_phase   = PhIdle;
    ramp_held    = 8'd0;
    ramp_period  = scsaw_pkg::StepPeriodRst;
    ramp_ticks   = 8'd0;
    ramp_running = 1'b1;
    ramp_falling = 1'b0;
    ramp_level   = 8'd0;
  endtask

  task automatic predict_duty(input logic kind, input logic [7:0] b, output duty_result_t r);
    logic       wrote;
    logic [7:0] full;
    wrote = 1'b0;
    full  = (ramp_full == 8'd0) ? 8'd1 : ramp_full;
    if (kind == scsaw_pkg::KindTick) begin
      if (ramp_running) begin
        if ({1'b0, ramp_ticks} + 9'd1 < {1'b0, ramp_period}) begin
          ramp_ticks = ramp_ticks + 8'd1;
        end else begin
          ramp_ticks = 8'd0;
          wrote = 1'b1;
          if (!ramp_falling) begin
            if (ramp_level >= full) ramp_level = 8'd0;
            ramp_level = ramp_level + 8'd1;
          end else begin
            if (ramp_level == 8'd0) ramp_level = full;
            ramp_level = ramp_level - 8'd1;
          end
        end
      end
    end else if (b == scsaw_pkg::SyncByte) begin
      ramp_phase = PhCmd;
    end else begin
      if (ramp_phase == PhCmd) begin
        ramp_held = b;
      end else if (ramp_phase == PhData) begin
        ramp_period  = b;
        ramp_running = 1'b1;
        case (ramp_held)
          scsaw_pkg::CmdStop: begin
            ramp_running = 1'b0;
            ramp_level   = 8'd0;
            wrote        = 1'b1;
          end
          scsaw_pkg::CmdFall: begin
            ramp_falling = 1'b1;
            ramp_level   = full;
            wrote        = 1'b1;
          end
          scsaw_pkg::CmdRise: begin
            ramp_falling = 1'b0;
            ramp_level   = 8'd0;
            wrote        = 1'b1;
          end
          default: ;
        endcase
      end
      // a non-sync byte advances the phase even when idle
      ramp_phase = (ramp_phase >= PhData) ? PhIdle : ramp_phase + 2'd1;
    end
    r.duty    = ramp_level;
    r.written = wrote;
  endtask

  task automatic send_item(input logic kind, input logic [7:0] b);
    duty_result_t r;
    int           gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_duty(kind, b, r);
    duty_q.push_back(r);
  endtask

  task automatic send_packet(input logic [7:0] cmd, input logic [7:0] data);
    send_item(scsaw_pkg::KindByte, scsaw_pkg::SyncByte);
    send_item(scsaw_pkg::KindByte, cmd);
    send_item(scsaw_pkg::KindByte, data);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(scsaw_pkg::KindTick, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain_results();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (duty_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_full_scale(input logic [7:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ramp_full = v;
  endtask

  // result side: check each transfer, then pick the next ready
  int stall_mode = 0;
  int mode_left  = 0;
  int rx_cnt     = 0;

  always @(posedge clk) begin
    duty_result_t exp_r;
    if (rst_n && m_tvalid && m_tready) begin
      if (duty_q.size() == 0) begin
        $error("unexpected result: duty %0d, duty_written %0b", m_tdata, m_tuser);
        fails++;
      end else begin
        exp_r = duty_q.pop_front();
        if (m_tdata !== exp_r.duty) begin
          $error("duty: expected %0d, actual %0d", exp_r.duty, m_tdata);
          fails++;
        end
        if (m_tuser !== exp_r.written) begin
          $error("duty_written: expected %0b, actual %0b", exp_r.written, m_tuser);
          fails++;
        end
      end
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(32, 256);
    end
    mode_left--;
    rx_cnt++;
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 9) < 7);
      default: m_tready <= ((rx_cnt % 7) > 2);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("serial_commanded_sawtooth_pwm_ramp regression: fail");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    // period 10 after reset: no step yet; tick ignores its byte
    send_item(scsaw_pkg::KindTick, 8'h00);
    send_item(scsaw_pkg::KindTick, scsaw_pkg::SyncByte);
  endtask

  task automatic test_commands();
    send_packet(scsaw_pkg::CmdRise, 8'd0);
    send_ticks(2);
    send_packet(scsaw_pkg::CmdFall, 8'd1);
    send_ticks(2);
    send_packet(scsaw_pkg::CmdStop, 8'd0);
    send_ticks(1);
    // unknown command only resumes; falling from 0 wraps to full-1
    send_packet(8'd3, 8'd0);
    send_ticks(1);
  endtask

  task automatic test_parser_quirks();
    // idle byte advances the phase, so this forms a packet without sync
    send_item(scsaw_pkg::KindByte, 8'h00);
    send_item(scsaw_pkg::KindByte, scsaw_pkg::CmdRise);
    send_item(scsaw_pkg::KindByte, 8'hFE);
    // sync in the data phase restarts the packet
    send_item(scsaw_pkg::KindByte, scsaw_pkg::SyncByte);
    send_item(scsaw_pkg::KindByte, scsaw_pkg::CmdFall);
    send_item(scsaw_pkg::KindByte, scsaw_pkg::SyncByte);
    send_packet(scsaw_pkg::CmdFall, 8'd2);
  endtask

  task automatic test_random_traffic();
    int          count;
    int unsigned pick;
    logic [7:0]  cmd;
    logic [7:0]  data;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       write_full_scale(8'd1);
        1:       write_full_scale(8'd255);
        2:       write_full_scale(8'd2);
        3:       write_full_scale(8'd5);
        default: write_full_scale(8'($urandom_range(1, 255)));
      endcase
      count = 0;
      while (count < 250) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          case ($urandom_range(0, 4))
            0:       cmd = scsaw_pkg::CmdRise;
            1:       cmd = scsaw_pkg::CmdFall;
            2:       cmd = scsaw_pkg::CmdStop;
            3:       cmd = scsaw_pkg::CmdRise;
            default: cmd = 8'($urandom_range(0, 254));
          endcase
          data = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 254))
                                             : 8'($urandom_range(0, 3));
          send_packet(cmd, data);
          count += 3;
        end else if (pick < 85) begin
          int n;
          n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
          send_ticks(n);
          count += n;
        end else if (pick < 93) begin
          send_item(scsaw_pkg::KindByte, 8'($urandom_range(0, 255)));
          count++;
        end else begin
          // broken packet: sync and command, then no data
          send_item(scsaw_pkg::KindByte, scsaw_pkg::SyncByte);
          send_item(scsaw_pkg::KindByte, 8'($urandom_range(0, 254)));
          count += 2;
        end
      end
    end
  endtask

  initial begin
    ramp_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_commands();
    test_parser_quirks();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("serial_commanded_sawtooth_pwm_ramp regression: pass");
    end else begin
      $display("serial_commanded_sawtooth_pwm_ramp regression: fail");
    end
    $finish;
  end

endmodule
